[rtl/core/llrs_pkg.sv]
// Shared types and constants for the least loaded replica select unit.
`default_nettype none

package llrs_pkg;

    // Sizing of the target table and the request.
    localparam int MAX_TARGETS = 64;
    localparam int MAX_REPL    = 8;
    localparam int LOAD_WIDTH  = 16;

    localparam int TGT_W  = $clog2(MAX_TARGETS);
    localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
    localparam int REPL_W = $clog2(MAX_REPL + 1);

    // Fixed widths of the configuration registers.
    localparam int TC_W       = 7;
    localparam int RC_W       = 4;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TC_W-1:0] TC_RESET = TC_W'(64);
    localparam logic [RC_W-1:0] RC_RESET = RC_W'(3);

    localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = '1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLICA_COUNT = 1'b1;

    // Operation codes.
    localparam logic OP_SELECT  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_MIN,
        ST_SEL,
        ST_REL_RD,
        ST_REL_WR
    } state_t;

    // One chosen target handed to the output register.
    typedef struct packed {
        logic             vld;
        logic [TGT_W-1:0] tgt;
        logic             last;
    } emit_t;

    // Access request to the load counter memory.
    typedef struct packed {
        logic                  rd_en;
        logic [TGT_W-1:0]      rd_addr;
        logic                  wr_en;
        logic [TGT_W-1:0]      wr_addr;
        logic [LOAD_WIDTH-1:0] wr_data;
    } ram_req_t;

endpackage

`default_nettype wire

[rtl/core/llrs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module llrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/llrs_seq.sv]
// Scan sequencer: start reduction, minimum search, selection pass and release.
`default_nettype none

module llrs_seq
    import llrs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_accept,
    input  wire logic                  op,
    input  wire logic [TGT_W-1:0]      start_target,
    input  wire logic [TGT_W-1:0]      release_target,
    input  wire logic [CNT_W-1:0]      n_eff,
    input  wire logic [REPL_W-1:0]     want,
    input  wire logic                  out_free,
    input  wire logic [LOAD_WIDTH-1:0] ram_rd_data,
    output ram_req_t                   ram_req,
    output emit_t                      emit,
    output logic                       busy
);

    state_t                  st_reg, st_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [TGT_W-1:0]        src_reg, src_next;
    logic                    p1_vld_reg, p1_vld_next;
    logic [TGT_W-1:0]        p1_idx_reg, p1_idx_next;
    logic [LOAD_WIDTH-1:0]   thr_reg, thr_next;
    logic                    any_reg, any_next;
    logic [REPL_W-1:0]       got_reg, got_next;
    logic [REPL_W-1:0]       want_reg, want_next;
    logic [MAX_TARGETS-1:0]  taken_reg, taken_next;
    logic [MAX_TARGETS-1:0]  vld_reg, vld_next;

    logic [LOAD_WIDTH-1:0]   p1_load;
    logic [LOAD_WIDTH-1:0]   rel_load;
    logic [CNT_W-1:0]        mod_shift;
    logic [CNT_W-1:0]        mod_rem;
    logic [CNT_W-1:0]        sel_sum;
    logic [TGT_W-1:0]        sel_tgt;
    logic                    scan_left;
    logic                    sel_hit;
    logic                    sel_hold;
    logic                    sel_issue;
    logic                    min_done;
    logic                    sel_done;
    logic                    mod_done;
    logic                    rel_in_range;

    // Load seen at the read stage; an entry never written reads as zero.
    assign p1_load  = vld_reg[p1_idx_reg] ? ram_rd_data : '0;
    assign rel_load = vld_reg[src_reg] ? ram_rd_data : '0;

    // One restoring step of the start index reduction modulo the target count.
    assign mod_shift = {rem_reg[CNT_W-2:0], src_reg[TGT_W-1]};
    assign mod_rem   = (mod_shift >= n_eff) ? (mod_shift - n_eff) : mod_shift;
    assign mod_done  = (cnt_reg == CNT_W'(TGT_W - 1));

    // Circular scan position for the selection pass.
    assign sel_sum = CNT_W'(rem_reg[TGT_W-1:0]) + cnt_reg;
    assign sel_tgt = (sel_sum >= n_eff) ? TGT_W'(sel_sum - n_eff) : sel_sum[TGT_W-1:0];

    assign scan_left = (cnt_reg < n_eff);

    // Selection stage: a hit waits while the output register is full.
    assign sel_hit   = p1_vld_reg && !taken_reg[p1_idx_reg] &&
                       (p1_load <= thr_reg) && (got_reg < want_reg);
    assign sel_hold  = sel_hit && !out_free;
    assign sel_issue = !sel_hold && scan_left && (got_reg < want_reg);

    // Pass completion once the read stage has drained.
    assign min_done = !scan_left && !p1_vld_reg;
    assign sel_done = (!scan_left || (got_reg == want_reg)) && !p1_vld_reg;

    assign rel_in_range = (CNT_W'(src_reg) < n_eff);

    assign busy = (st_reg != ST_IDLE);

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == OP_RELEASE)
                    begin
                        st_next = ST_REL_RD;
                    end
                    else if (want != '0)
                    begin
                        st_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    st_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (min_done)
                begin
                    st_next = any_reg ? ST_SEL : ST_IDLE;
                end
            end
            ST_SEL:
            begin
                if (sel_done)
                begin
                    st_next = (got_reg == want_reg) ? ST_IDLE : ST_MIN;
                end
            end
            ST_REL_RD:
            begin
                st_next = rel_in_range ? ST_REL_WR : ST_IDLE;
            end
            ST_REL_WR:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        src_next    = src_reg;
        p1_vld_next = p1_vld_reg;
        p1_idx_next = p1_idx_reg;
        thr_next    = thr_reg;
        any_next    = any_reg;
        got_next    = got_reg;
        want_next   = want_reg;
        taken_next  = taken_reg;
        vld_next    = vld_reg;
        ram_req     = '0;
        emit        = '0;

        case (st_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == OP_RELEASE)
                    begin
                        src_next = release_target;
                    end
                    else
                    begin
                        src_next   = start_target;
                        want_next  = want;
                        cnt_next   = '0;
                        rem_next   = '0;
                        got_next   = '0;
                        any_next   = 1'b0;
                        taken_next = '0;
                    end
                end
            end
            ST_MOD:
            begin
                rem_next = mod_rem;
                src_next = {src_reg[TGT_W-2:0], 1'b0};
                cnt_next = mod_done ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_MIN:
            begin
                // Track the smallest load among targets not yet chosen.
                if (p1_vld_reg && !taken_reg[p1_idx_reg] &&
                    (!any_reg || (p1_load < thr_reg)))
                begin
                    thr_next = p1_load;
                    any_next = 1'b1;
                end
                // Read the targets in index order, one per cycle.
                p1_vld_next = scan_left;
                if (scan_left)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = cnt_reg[TGT_W-1:0];
                    p1_idx_next     = cnt_reg[TGT_W-1:0];
                    cnt_next        = cnt_reg + CNT_W'(1);
                end
                if (min_done)
                begin
                    cnt_next = '0;
                end
            end
            ST_SEL:
            begin
                // Choose, count up the load and hand the word to the output.
                if (sel_hit && out_free)
                begin
                    emit.vld        = 1'b1;
                    emit.tgt        = p1_idx_reg;
                    emit.last       = ((got_reg + REPL_W'(1)) == want_reg);
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = p1_idx_reg;
                    ram_req.wr_data = (p1_load == LOAD_MAX) ? p1_load
                                                            : p1_load + LOAD_WIDTH'(1);
                    taken_next[p1_idx_reg] = 1'b1;
                    vld_next[p1_idx_reg]   = 1'b1;
                    got_next = got_reg + REPL_W'(1);
                end
                // Circular reads from the start index; all held during a wait.
                if (!sel_hold)
                begin
                    p1_vld_next = sel_issue;
                    if (sel_issue)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = sel_tgt;
                        p1_idx_next     = sel_tgt;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                end
                if (sel_done)
                begin
                    cnt_next = '0;
                    any_next = 1'b0;
                end
            end
            ST_REL_RD:
            begin
                if (rel_in_range)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = src_reg;
                end
            end
            ST_REL_WR:
            begin
                if (rel_load != '0)
                begin
                    ram_req.wr_en     = 1'b1;
                    ram_req.wr_addr   = src_reg;
                    ram_req.wr_data   = rel_load - LOAD_WIDTH'(1);
                    vld_next[src_reg] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            cnt_reg    <= '0;
            p1_vld_reg <= 1'b0;
            any_reg    <= 1'b0;
            got_reg    <= '0;
            want_reg   <= '0;
            taken_reg  <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            cnt_reg    <= cnt_next;
            p1_vld_reg <= p1_vld_next;
            any_reg    <= any_next;
            got_reg    <= got_next;
            want_reg   <= want_next;
            taken_reg  <= taken_next;
            vld_reg    <= vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        src_reg    <= src_next;
        p1_idx_reg <= p1_idx_next;
        thr_reg    <= thr_next;
    end

endmodule

`default_nettype wire

[rtl/core/least_loaded_replica_select_unit.sv]
// Top level of the least loaded replica select unit.
//
// The unit keeps one load counter per target in a RAM with one read and
// one write port and picks distinct, least loaded targets for each select
// word, scanning circularly from the start index; each chosen target comes
// out as one word, the final one marked by last, and its counter goes up
// by one. A release word lowers one counter. Words are taken one at a time:
// a release reads its counter and then writes it back lowered; a select
// first reduces the start index modulo the target count, then runs per
// pass a minimum search and a selection, with at most one pass per
// replica. The RAM serves one read per cycle, while a stalled output
// holds the selection pass. Counters read as zero after reset with no
// clearing pass.
`default_nettype none

module least_loaded_replica_select_unit
    import llrs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire logic [TGT_W-1:0]      start_target,
    input  wire logic [TGT_W-1:0]      release_target,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [TGT_W-1:0]           chosen_target,
    output logic                       last
);

    logic [TC_W-1:0]       target_count_reg;
    logic [RC_W-1:0]       replica_count_reg;
    logic [CNT_W-1:0]      n_eff;
    logic [REPL_W-1:0]     want_cap;
    logic [REPL_W-1:0]     want;
    logic                  busy;
    logic                  in_accept;
    logic                  out_free;
    logic                  out_valid_reg, out_valid_next;
    logic [TGT_W-1:0]      out_tgt_reg;
    logic                  out_last_reg;
    ram_req_t              ram_req;
    emit_t                 emit;
    logic [LOAD_WIDTH-1:0] ram_rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg  <= TC_RESET;
            replica_count_reg <= RC_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_TARGET_COUNT:  target_count_reg  <= cfg_wr_data[TC_W-1:0];
                CFG_REPLICA_COUNT: replica_count_reg <= cfg_wr_data[RC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective target count and replicas per select.
    always_comb
    begin
        if (target_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(target_count_reg) > MAX_TARGETS)
        begin
            n_eff = CNT_W'(MAX_TARGETS);
        end
        else
        begin
            n_eff = CNT_W'(target_count_reg);
        end

        if (32'(replica_count_reg) > MAX_REPL)
        begin
            want_cap = REPL_W'(MAX_REPL);
        end
        else
        begin
            want_cap = REPL_W'(replica_count_reg);
        end

        if (32'(want_cap) > 32'(n_eff))
        begin
            want = REPL_W'(n_eff);
        end
        else
        begin
            want = want_cap;
        end
    end

    // Input handshake: one word at a time.
    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;

    llrs_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_accept      (in_accept),
        .op             (op),
        .start_target   (start_target),
        .release_target (release_target),
        .n_eff          (n_eff),
        .want           (want),
        .out_free       (out_free),
        .ram_rd_data    (ram_rd_data),
        .ram_req        (ram_req),
        .emit           (emit),
        .busy           (busy)
    );

    llrs_ram #(
        .WIDTH (LOAD_WIDTH),
        .DEPTH (MAX_TARGETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: loads a new word whenever the current one leaves.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (emit.vld)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.vld)
        begin
            out_tgt_reg  <= emit.tgt;
            out_last_reg <= emit.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign chosen_target = out_tgt_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire
